/* hdl/cbp_pkg.sv */
// Shared types and constants for the command batch parser.
`timescale 1ns / 1ps

package cbp_pkg;

  // Batch framing
  localparam logic [31:0] MAGIC_WORD       = 32'h5247_5055;
  localparam logic [31:0] HEADER_BYTES     = 32'd20;
  localparam logic [31:0] HEAD_BYTES       = 32'd12;
  localparam logic [31:0] MAGIC_BYTES      = 32'd4;
  localparam logic [31:0] LEN_FIRST_BYTE   = 32'd8;
  localparam int          STAGE_DEPTH      = 16;
  localparam logic [31:0] STAGE_LIMIT      = 32'(STAGE_DEPTH);

  // Record opcodes and argument minimums
  localparam logic [31:0] OP_TEXTURE       = 32'd101;
  localparam logic [31:0] OP_CLEAR         = 32'd142;
  localparam logic [31:0] OP_PRESENT       = 32'd180;
  localparam logic [31:0] TEXTURE_MIN_ARGS = 32'd12;
  localparam logic [31:0] CLEAR_MIN_ARGS   = 32'd16;

  // Held value defaults
  localparam logic [31:0] DEFAULT_SIZE     = 32'd64;
  localparam logic [31:0] ALPHA_ONE        = 32'h3F80_0000;

  // Result status codes
  localparam logic [1:0]  STATUS_OK        = 2'd0;
  localparam logic [1:0]  STATUS_SHORT     = 2'd1;
  localparam logic [1:0]  STATUS_BAD_MAGIC = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_RECORD,
    PH_ARGS,
    PH_REJECT
  } phase_t;

  typedef struct packed {
    logic [7:0] batch_byte;
    logic       last_byte;
  } cbp_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] frame_width;
    logic [31:0] frame_height;
    logic [31:0] clear_red_bits;
    logic [31:0] clear_green_bits;
    logic [31:0] clear_blue_bits;
    logic [31:0] clear_alpha_bits;
    logic        clear_seen;
    logic        present_seen;
  } cbp_out_t;

endpackage

/* hdl/cbp_parser.sv */
// Parse state, record staging and held values for the command batch parser.
`timescale 1ns / 1ps

module cbp_parser import cbp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  cbp_in_t  item,
  output cbp_out_t summary
);

  phase_t      phase, phase_next;
  logic [31:0] section_count, section_count_next, count_inc;
  logic [31:0] magic_shift, magic_shift_next;
  logic [31:0] record_opcode, record_opcode_next;
  logic [31:0] record_arg_length, record_arg_length_next;
  logic [7:0]  staged_args [STAGE_DEPTH];
  logic [7:0]  staged_args_next [STAGE_DEPTH];
  logic [31:0] held_width, held_width_next;
  logic [31:0] held_height, held_height_next;
  logic [31:0] held_clear [4];
  logic [31:0] held_clear_next [4];
  logic        clear_flag, clear_flag_next;
  logic        present_flag, present_flag_next;
  logic        apply;
  logic [7:0]  b;

  assign b         = item.batch_byte;
  assign count_inc = section_count + 32'd1;

  // Phase transitions
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HEADER: begin
        if (count_inc >= HEADER_BYTES) begin
          phase_next = (magic_shift_next == MAGIC_WORD) ? PH_RECORD : PH_REJECT;
        end
      end
      PH_RECORD: begin
        if (count_inc >= HEAD_BYTES && record_arg_length_next != 32'd0) begin
          phase_next = PH_ARGS;
        end
      end
      PH_ARGS: begin
        if (count_inc >= record_arg_length) begin
          phase_next = PH_RECORD;
        end
      end
      PH_REJECT: phase_next = PH_REJECT;
      default:   phase_next = PH_HEADER;
    endcase
  end

  // Byte capture and section counting
  always_comb begin
    section_count_next     = section_count;
    magic_shift_next       = magic_shift;
    record_opcode_next     = record_opcode;
    record_arg_length_next = record_arg_length;
    staged_args_next       = staged_args;
    apply                  = 1'b0;
    unique case (phase)
      PH_HEADER: begin
        if (section_count < MAGIC_BYTES) begin
          magic_shift_next[{section_count[1:0], 3'b000} +: 8] = b;
        end
        section_count_next = (count_inc >= HEADER_BYTES) ? 32'd0 : count_inc;
      end
      PH_RECORD: begin
        if (section_count == 32'd0) begin
          record_opcode_next     = '0;
          record_arg_length_next = '0;
        end
        if (section_count < MAGIC_BYTES) begin
          record_opcode_next[{section_count[1:0], 3'b000} +: 8] = b;
        end else if (section_count >= LEN_FIRST_BYTE && section_count < HEAD_BYTES) begin
          record_arg_length_next[{section_count[1:0], 3'b000} +: 8] = b;
        end
        section_count_next = count_inc;
        if (count_inc >= HEAD_BYTES) begin
          section_count_next = 32'd0;
          apply              = (record_arg_length_next == 32'd0);
        end
      end
      PH_ARGS: begin
        if (section_count < STAGE_LIMIT) begin
          staged_args_next[section_count[3:0]] = b;
        end
        section_count_next = count_inc;
        if (count_inc >= record_arg_length) begin
          section_count_next = 32'd0;
          apply              = 1'b1;
        end
      end
      PH_REJECT: ;
      default:   ;
    endcase
  end

  // Record application, using the byte that arrives this cycle
  always_comb begin
    held_width_next   = held_width;
    held_height_next  = held_height;
    held_clear_next   = held_clear;
    clear_flag_next   = clear_flag;
    present_flag_next = present_flag;
    if (apply) begin
      if (record_opcode_next == OP_TEXTURE && record_arg_length_next >= TEXTURE_MIN_ARGS) begin
        held_width_next  = {staged_args_next[3], staged_args_next[2],
                            staged_args_next[1], staged_args_next[0]};
        held_height_next = {staged_args_next[7], staged_args_next[6],
                            staged_args_next[5], staged_args_next[4]};
      end else if (record_opcode_next == OP_CLEAR &&
                   record_arg_length_next >= CLEAR_MIN_ARGS) begin
        for (int i = 0; i < 4; i++) begin
          held_clear_next[i] = {staged_args_next[4*i+3], staged_args_next[4*i+2],
                                staged_args_next[4*i+1], staged_args_next[4*i]};
        end
        clear_flag_next = 1'b1;
      end else if (record_opcode_next == OP_PRESENT) begin
        present_flag_next = 1'b1;
      end
    end
  end

  // Result seen after this byte
  always_comb begin
    summary.status = STATUS_OK;
    if (phase_next == PH_HEADER) begin
      summary.status = STATUS_SHORT;
    end else if (phase_next == PH_REJECT) begin
      summary.status = STATUS_BAD_MAGIC;
    end
    summary.frame_width      = held_width_next;
    summary.frame_height     = held_height_next;
    summary.clear_red_bits   = held_clear_next[0];
    summary.clear_green_bits = held_clear_next[1];
    summary.clear_blue_bits  = held_clear_next[2];
    summary.clear_alpha_bits = held_clear_next[3];
    summary.clear_seen       = clear_flag_next;
    summary.present_seen     = present_flag_next;
  end

  // Parse state; the final byte returns everything to defaults
  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      phase             <= PH_HEADER;
      section_count     <= '0;
      magic_shift       <= '0;
      record_opcode     <= '0;
      record_arg_length <= '0;
      held_width        <= DEFAULT_SIZE;
      held_height       <= DEFAULT_SIZE;
      held_clear[0]     <= '0;
      held_clear[1]     <= '0;
      held_clear[2]     <= '0;
      held_clear[3]     <= ALPHA_ONE;
      clear_flag        <= 1'b0;
      present_flag      <= 1'b0;
    end else if (step) begin
      phase             <= phase_next;
      section_count     <= section_count_next;
      magic_shift       <= magic_shift_next;
      record_opcode     <= record_opcode_next;
      record_arg_length <= record_arg_length_next;
      held_width        <= held_width_next;
      held_height       <= held_height_next;
      held_clear        <= held_clear_next;
      clear_flag        <= clear_flag_next;
      present_flag      <= present_flag_next;
    end
  end

  // Argument staging bytes, no reset
  always_ff @(posedge clk) begin
    if (step) begin
      staged_args <= staged_args_next;
    end
  end

endmodule

/* hdl/command_batch_parser.sv */
// Top level of the command batch parser: input register, parser and result register.
//
// Usage:
//   The batch channel (batch_valid, batch_stall, batch) carries one byte of a
//   command batch per transaction, with last_byte set on the final byte.
//   The result channel (result_valid, result_stall, result) carries one
//   transaction per batch: status and the width, height, clear words and
//   flags gathered from the records.
//   Throughput: one byte per cycle while batch_stall is low. Every byte is
//   parsed by combinational counter and byte-capture logic between the input
//   register and the result register.
//   The final byte is taken into the input register and is then parsed into
//   the result register, where result_valid is set; it waits in the input
//   register while batch_stall is raised.
//   Stalls: bytes keep flowing while a result waits; only a final byte in
//   the input register waits for the result register to empty, and then
//   batch_stall is raised.
//   Reset: rst (synchronous, active high) empties both registers and puts
//   the parser in the header phase with default held values; the parser
//   also returns to those defaults after each final byte.
`timescale 1ns / 1ps

module command_batch_parser import cbp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     batch_valid,
  output logic     batch_stall,
  input  cbp_in_t  batch,
  output logic     result_valid,
  input  logic     result_stall,
  output cbp_out_t result
);

  logic     hold_valid;
  cbp_in_t  hold;
  logic     blocked;
  logic     step;
  cbp_out_t summary;

  // A final byte waits while an earlier result is still stalled
  assign blocked     = hold_valid && hold.last_byte && result_valid && result_stall;
  assign step        = hold_valid && !blocked;
  assign batch_stall = blocked;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!blocked) begin
      hold_valid <= batch_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!blocked && batch_valid) begin
      hold <= batch;
    end
  end

  cbp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .item    (hold),
    .summary (summary)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && hold.last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && hold.last_byte) begin
      result <= summary;
    end
  end

endmodule

/* verif/command_batch_parser_test.sv */
// Self-checking testbench for command_batch_parser: directed batch table, then random batches.
`timescale 1ns / 1ps

module command_batch_parser_test;
  import cbp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RESET_CYCLES = 12;
  localparam int REC_NONE     = 0;
  localparam int REC_FULL     = -1;

  // One row of the directed table: how to build the batch, and its result if obvious
  typedef struct packed {
    logic [31:0] magic;
    logic [7:0]  hdr_len;
    logic [31:0] opcode;
    logic [31:0] arg_len;
    int          rec_cut;
    logic        fill_random;
    logic [7:0]  fill_byte;
    logic        known;
    cbp_out_t    known_res;
  } batch_row_t;

  logic     clk          = 1'b0;
  logic     rst          = 1'b1;
  logic     batch_valid  = 1'b0;
  cbp_in_t  batch        = '0;
  logic     result_stall = 1'b0;
  logic     batch_stall;
  logic     result_valid;
  cbp_out_t result;

  int send_pct = 0;
  int recv_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int batch_count = 0;
  int byte_count = 0;
  int status_tally [3];
  int clear_tally = 0;
  int present_tally = 0;

  batch_row_t directed_rows[$];
  logic [7:0] batch_bytes[$];
  cbp_out_t   pending_results[$];

  // Parser shadow state
  phase_t      model_phase;
  logic [31:0] model_count;
  logic [31:0] model_magic;
  logic [31:0] model_opcode;
  logic [31:0] model_arg_len;
  logic [7:0]  model_stage [STAGE_DEPTH];
  logic [31:0] model_width;
  logic [31:0] model_height;
  logic [31:0] model_clear [4];
  logic        model_clear_flag;
  logic        model_present_flag;

  command_batch_parser dut (
    .clk          (clk),
    .rst          (rst),
    .batch_valid  (batch_valid),
    .batch_stall  (batch_stall),
    .batch        (batch),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic cbp_out_t default_result(input logic [1:0] status);
    cbp_out_t r;
    r.status           = status;
    r.frame_width      = DEFAULT_SIZE;
    r.frame_height     = DEFAULT_SIZE;
    r.clear_red_bits   = '0;
    r.clear_green_bits = '0;
    r.clear_blue_bits  = '0;
    r.clear_alpha_bits = ALPHA_ONE;
    r.clear_seen       = 1'b0;
    r.present_seen     = 1'b0;
    return r;
  endfunction

  task automatic reset_model();
    model_phase        = PH_HEADER;
    model_count        = '0;
    model_magic        = '0;
    model_opcode       = '0;
    model_arg_len      = '0;
    model_width        = DEFAULT_SIZE;
    model_height       = DEFAULT_SIZE;
    model_clear[0]     = '0;
    model_clear[1]     = '0;
    model_clear[2]     = '0;
    model_clear[3]     = ALPHA_ONE;
    model_clear_flag   = 1'b0;
    model_present_flag = 1'b0;
  endtask

  function automatic logic [31:0] stage_word(input int at);
    return {model_stage[at + 3], model_stage[at + 2], model_stage[at + 1], model_stage[at]};
  endfunction

  // Apply a record whose head and arguments have all arrived
  task automatic commit_record();
    int i;
    if (model_opcode == OP_TEXTURE && model_arg_len >= TEXTURE_MIN_ARGS) begin
      model_width  = stage_word(0);
      model_height = stage_word(4);
    end else if (model_opcode == OP_CLEAR && model_arg_len >= CLEAR_MIN_ARGS) begin
      for (i = 0; i < 4; i++) model_clear[i] = stage_word(4 * i);
      model_clear_flag = 1'b1;
    end else if (model_opcode == OP_PRESENT) begin
      model_present_flag = 1'b1;
    end
  endtask

  // Advance the shadow parser by one accepted byte; on the final byte give the result
  task automatic track_batch_byte(input logic [7:0] b, input logic last,
                                  output logic done, output cbp_out_t res);
    done = 1'b0;
    res  = '0;
    case (model_phase)
      PH_HEADER: begin
        if (model_count < MAGIC_BYTES) model_magic |= 32'(b) << (8 * model_count);
        model_count++;
        if (model_count >= HEADER_BYTES) begin
          model_count = '0;
          model_phase = (model_magic == MAGIC_WORD) ? PH_RECORD : PH_REJECT;
        end
      end
      PH_RECORD: begin
        if (model_count == 0) begin
          model_opcode  = '0;
          model_arg_len = '0;
        end
        if (model_count < MAGIC_BYTES)
          model_opcode |= 32'(b) << (8 * model_count);
        else if (model_count >= LEN_FIRST_BYTE && model_count < HEAD_BYTES)
          model_arg_len |= 32'(b) << (8 * (model_count - LEN_FIRST_BYTE));
        model_count++;
        if (model_count >= HEAD_BYTES) begin
          model_count = '0;
          if (model_arg_len == 0) commit_record();
          else model_phase = PH_ARGS;
        end
      end
      PH_ARGS: begin
        // only the first 16 argument bytes are kept
        if (model_count < STAGE_LIMIT) model_stage[model_count[3:0]] = b;
        model_count++;
        if (model_count >= model_arg_len) begin
          commit_record();
          model_count = '0;
          model_phase = PH_RECORD;
        end
      end
      default: ;
    endcase

    if (last) begin
      done = 1'b1;
      case (model_phase)
        PH_HEADER: res.status = STATUS_SHORT;
        PH_REJECT: res.status = STATUS_BAD_MAGIC;
        default:   res.status = STATUS_OK;
      endcase
      res.frame_width      = model_width;
      res.frame_height     = model_height;
      res.clear_red_bits   = model_clear[0];
      res.clear_green_bits = model_clear[1];
      res.clear_blue_bits  = model_clear[2];
      res.clear_alpha_bits = model_clear[3];
      res.clear_seen       = model_clear_flag;
      res.present_seen     = model_present_flag;
      reset_model();
    end
  endtask

  // Batch assembly helpers
  task automatic add_word(input logic [31:0] w);
    int k;
    for (k = 0; k < 4; k++) batch_bytes.push_back(w[8 * k +: 8]);
  endtask

  task automatic add_random(input int n);
    repeat (n) batch_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic trim_batch(input int n);
    while (batch_bytes.size() > n) batch_bytes.delete(batch_bytes.size() - 1);
  endtask

  task automatic add_record(input logic [31:0] opcode, input logic [31:0] arg_len,
                            input logic fill_random, input logic [7:0] fill_byte);
    add_word(opcode);
    add_word($urandom);
    add_word(arg_len);
    repeat (arg_len) begin
      if (fill_random) add_random(1);
      else batch_bytes.push_back(fill_byte);
    end
  endtask

  task automatic add_row(input logic [31:0] magic, input int hdr_len,
                         input logic [31:0] opcode, input logic [31:0] arg_len,
                         input int rec_cut, input logic fill_random,
                         input logic [7:0] fill_byte, input logic known,
                         input cbp_out_t known_res);
    batch_row_t row;
    row.magic       = magic;
    row.hdr_len     = 8'(hdr_len);
    row.opcode      = opcode;
    row.arg_len     = arg_len;
    row.rec_cut     = rec_cut;
    row.fill_random = fill_random;
    row.fill_byte   = fill_byte;
    row.known       = known;
    row.known_res   = known_res;
    directed_rows.push_back(row);
  endtask

  // Directed table: header length, one record, how much of it is sent
  task automatic load_directed();
    cbp_out_t r;
    r = default_result(STATUS_SHORT);
    //      magic             hdr opcode         len  cut       rnd fill   known
    add_row(32'h0000_0000,    1,  32'd0,         0,   REC_NONE, 0, 8'h00, 1, r);
    add_row(32'hFFFF_FFFF,    1,  32'd0,         0,   REC_NONE, 0, 8'h00, 1, r);
    add_row(MAGIC_WORD,       19, 32'd0,         0,   REC_NONE, 0, 8'h00, 1, r);
    r = default_result(STATUS_BAD_MAGIC);
    add_row(32'hFFFF_FFFF,    20, OP_TEXTURE,    12,  REC_FULL, 1, 8'h00, 1, r);
    add_row(MAGIC_WORD ^ 32'h1, 20, 32'd0,       0,   REC_NONE, 0, 8'h00, 1, r);
    r = default_result(STATUS_OK);
    add_row(MAGIC_WORD,       20, 32'd0,         0,   REC_NONE, 0, 8'h00, 1, r);
    add_row(MAGIC_WORD,       20, OP_TEXTURE,    11,  REC_FULL, 1, 8'h00, 1, r);
    add_row(MAGIC_WORD,       20, OP_CLEAR,      15,  REC_FULL, 1, 8'h00, 1, r);
    add_row(MAGIC_WORD,       20, 32'hFFFF_FFFF, 3,   REC_FULL, 1, 8'h00, 1, r);
    // truncated head, then truncated argument run
    add_row(MAGIC_WORD,       20, OP_TEXTURE,    12,  7,        1, 8'h00, 1, r);
    add_row(MAGIC_WORD,       20, OP_TEXTURE,    12,  22,       1, 8'h00, 1, r);
    r.frame_width  = '1;
    r.frame_height = '1;
    add_row(MAGIC_WORD,       20, OP_TEXTURE,    12,  REC_FULL, 0, 8'hFF, 1, r);
    r.frame_width  = '0;
    r.frame_height = '0;
    add_row(MAGIC_WORD,       20, OP_TEXTURE,    12,  REC_FULL, 0, 8'h00, 1, r);
    r = default_result(STATUS_OK);
    r.clear_red_bits   = '1;
    r.clear_green_bits = '1;
    r.clear_blue_bits  = '1;
    r.clear_alpha_bits = '1;
    r.clear_seen       = 1'b1;
    add_row(MAGIC_WORD,       20, OP_CLEAR,      16,  REC_FULL, 0, 8'hFF, 1, r);
    r = default_result(STATUS_OK);
    r.present_seen = 1'b1;
    add_row(MAGIC_WORD,       20, OP_PRESENT,    0,   REC_FULL, 0, 8'h00, 1, r);
    add_row(MAGIC_WORD,       20, OP_PRESENT,    5,   REC_FULL, 1, 8'h00, 1, r);
    // values from random arguments, left to the shadow parser
    add_row(MAGIC_WORD,       20, OP_CLEAR,      16,  REC_FULL, 1, 8'h00, 0, r);
    add_row(MAGIC_WORD,       20, OP_TEXTURE,    40,  REC_FULL, 1, 8'h00, 0, r);
    add_row(MAGIC_WORD,       20, OP_CLEAR,      33,  REC_FULL, 1, 8'h00, 0, r);
  endtask

  task automatic build_directed(input batch_row_t row);
    batch_bytes.delete();
    add_word(row.magic);
    add_random(16);
    trim_batch(row.hdr_len);
    if (row.hdr_len == HEADER_BYTES && row.rec_cut != REC_NONE) begin
      add_record(row.opcode, row.arg_len, row.fill_random, row.fill_byte);
      if (row.rec_cut > 0) trim_batch(HEADER_BYTES + row.rec_cut);
    end
  endtask

  // Mostly well-formed batches with random records; some short or bad-magic noise
  task automatic make_random_batch(output logic formed);
    int sel;
    int nrec;
    int k;
    logic [31:0] opcode;
    logic [31:0] arg_len;
    batch_bytes.delete();
    formed = 1'b0;
    sel = $urandom_range(99);
    if (sel < 8) begin
      add_word($urandom_range(1) ? MAGIC_WORD : $urandom);
      add_random(16);
      trim_batch($urandom_range(1, HEADER_BYTES - 1));
    end else if (sel < 16) begin
      add_word($urandom_range(1) ? (MAGIC_WORD ^ (32'd1 << $urandom_range(31))) : $urandom);
      add_random(16 + $urandom_range(30));
    end else begin
      formed = 1'b1;
      add_word(MAGIC_WORD);
      add_random(16);
      nrec = $urandom_range(4);
      for (k = 0; k < nrec; k++) begin
        case ($urandom_range(9))
          0, 1, 2: begin
            opcode  = OP_TEXTURE;
            arg_len = ($urandom_range(99) < 80) ? $urandom_range(10, 14) : $urandom_range(40);
          end
          3, 4, 5: begin
            opcode  = OP_CLEAR;
            arg_len = ($urandom_range(99) < 80) ? $urandom_range(14, 18) : $urandom_range(40);
          end
          6, 7: begin
            opcode  = OP_PRESENT;
            arg_len = $urandom_range(6);
          end
          8: begin
            opcode  = $urandom;
            arg_len = $urandom_range(20);
          end
          default: begin
            opcode  = $urandom_range(255);
            arg_len = $urandom_range(20);
          end
        endcase
        add_record(opcode, arg_len, 1'b1, 8'h00);
      end
      if ($urandom_range(99) < 5) begin
        // random length field, usually far past the end of the batch
        add_word($urandom);
        add_word($urandom);
        add_word($urandom);
        add_random($urandom_range(20));
      end else if (nrec > 0 && $urandom_range(99) < 25) begin
        trim_batch(batch_bytes.size() - $urandom_range(1, 12));
      end
    end
  endtask

  // Drive one batch; the shadow parser runs on each accepted transaction
  task automatic send_batch(input logic use_known, input cbp_out_t known_res);
    cbp_in_t  item;
    logic     done;
    cbp_out_t res;
    int       i;
    for (i = 0; i < batch_bytes.size(); i++) begin
      item.batch_byte = batch_bytes[i];
      item.last_byte  = (i == batch_bytes.size() - 1);
      @(negedge clk);
      while ($urandom_range(99) < send_pct) begin
        batch_valid <= 1'b0;
        @(negedge clk);
      end
      batch_valid <= 1'b1;
      batch       <= item;
      @(posedge clk);
      while (batch_stall) @(posedge clk);
      track_batch_byte(item.batch_byte, item.last_byte, done, res);
      byte_count++;
      if (done) begin
        if (use_known) res = known_res;
        pending_results.push_back(res);
        status_tally[res.status]++;
        clear_tally   += res.clear_seen;
        present_tally += res.present_seen;
      end
    end
    batch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Receiver stalls
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < recv_pct);
  end

  // Result checking
  always @(posedge clk) begin : result_check
    cbp_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no batch outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(result.status));
        check_field("frame_width", want.frame_width, result.frame_width);
        check_field("frame_height", want.frame_height, result.frame_height);
        check_field("clear_red_bits", want.clear_red_bits, result.clear_red_bits);
        check_field("clear_green_bits", want.clear_green_bits, result.clear_green_bits);
        check_field("clear_blue_bits", want.clear_blue_bits, result.clear_blue_bits);
        check_field("clear_alpha_bits", want.clear_alpha_bits, result.clear_alpha_bits);
        check_field("clear_seen", 32'(want.clear_seen), 32'(result.clear_seen));
        check_field("present_seen", 32'(want.present_seen), 32'(result.present_seen));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int   ph;
    int   phase_bytes;
    int   phase_batches;
    logic formed;
    status_tally[0] = 0;
    status_tally[1] = 0;
    status_tally[2] = 0;
    reset_model();
    load_directed();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table, with light sender idling and heavy receiver stalls
    send_pct = 18;
    recv_pct = 66;
    foreach (directed_rows[i]) begin
      build_directed(directed_rows[i]);
      send_batch(directed_rows[i].known, directed_rows[i].known_res);
    end

    // Random batches in three idling regimes
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_pct = 18; recv_pct = 66; end
        1: begin send_pct = 66; recv_pct = 18; end
        default: begin send_pct = 0; recv_pct = 0; end
      endcase
      phase_bytes   = 0;
      phase_batches = 0;
      while (phase_bytes < 60 || phase_batches < 2) begin
        make_random_batch(formed);
        if (formed) phase_bytes += batch_bytes.size();
        send_batch(1'b0, '0);
        phase_batches++;
      end
    end

    @(negedge clk);
    batch_valid <= 1'b0;
    recv_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d batches in %0d bytes; statuses ok/short/bad magic: %0d/%0d/%0d",
             batch_count, byte_count, status_tally[0], status_tally[1], status_tally[2]);
    $display("Clear applied in %0d results, present in %0d", clear_tally, present_tally);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/cbp_pkg.sv
hdl/cbp_parser.sv
hdl/command_batch_parser.sv
verif/command_batch_parser_test.sv
